// ===== sv/format_string_integer_formatter_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the integer format-string formatter
// Concurrent assertion wrappers; defining NO_ASSERTIONS removes them all.
// ---------------------------------------------------------------------------
`ifndef FORMAT_STRING_INTEGER_FORMATTER_MACROS_SVH
`define FORMAT_STRING_INTEGER_FORMATTER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FSIF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("formatter assertion failed");
`define FSIF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("formatter assertion failed");
`else
`define FSIF_ASSERT_IMPL(label, ante, cons)
`define FSIF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/fsif_pkg.sv =====
// ---------------------------------------------------------------------------
// Formatter package
// Shared types, character codes and the digit-to-ASCII tables.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsif_pkg;

    typedef struct packed {
        logic load;
        logic hex;
        logic pop;
    } dig_cmd_t;

    typedef struct packed {
        logic       ready;
        logic       last;
        logic [3:0] digit;
    } dig_stat_t;

    typedef logic [7:0] char_t;

    localparam char_t CH_NUL     = 8'h00;
    localparam char_t CH_PERCENT = 8'h25;
    localparam char_t CH_MINUS   = 8'h2D;
    localparam char_t CH_ZERO    = 8'h30;
    localparam char_t CH_QMARK   = 8'h3F;
    localparam char_t CH_UC_X    = 8'h58;
    localparam char_t CH_LC_C    = 8'h63;
    localparam char_t CH_LC_D    = 8'h64;
    localparam char_t CH_LC_P    = 8'h70;
    localparam char_t CH_LC_U    = 8'h75;
    localparam char_t CH_LC_X    = 8'h78;

    localparam char_t HEX_UPPER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    localparam char_t HEX_LOWER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    function automatic char_t digit_char(input logic [3:0] digit, input logic upper);
        digit_char = upper ? HEX_UPPER[digit] : HEX_LOWER[digit];
    endfunction

endpackage

// ===== sv/fsif_digit_unit.sv =====
// ---------------------------------------------------------------------------
// Formatter digit unit
// Bit-serial binary to BCD conversion (shift and add-three) or direct hex load,
// leading-zero skipping and digit-by-digit release, most significant digit first.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsif_digit_unit #(
    parameter int ARG_BITS = 64,
    parameter int NDIG     = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fsif_pkg::dig_cmd_t   cmd,
    input  logic [ARG_BITS-1:0]  value,
    output fsif_pkg::dig_stat_t  stat
);

    localparam int DW     = 4 * NDIG;
    localparam int BIT_CW = $clog2(ARG_BITS + 1);
    localparam int DIG_CW = $clog2(NDIG + 1);

    localparam logic [1:0] PH_HOLD = 2'd0;
    localparam logic [1:0] PH_CONV = 2'd1;
    localparam logic [1:0] PH_SKIP = 2'd2;

    logic [1:0]          phase_reg, phase_next;
    logic [ARG_BITS-1:0] bin_reg, bin_next;
    logic [DW-1:0]       dig_reg, dig_next;
    logic [BIT_CW-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIG_CW-1:0]   dig_cnt_reg, dig_cnt_next;
    logic [DW-1:0]       adjusted;
    logic [3:0]          top_digit;

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            adjusted[4*i +: 4] = (dig_reg[4*i +: 4] >= 4'd5) ?
                                 dig_reg[4*i +: 4] + 4'd3 : dig_reg[4*i +: 4];
        end
    end

    assign top_digit   = dig_reg[DW-1 -: 4];
    assign stat.ready  = (phase_reg == PH_HOLD);
    assign stat.last   = (dig_cnt_reg == DIG_CW'(1));
    assign stat.digit  = top_digit;

    always_comb
    begin
        phase_next   = phase_reg;
        bin_next     = bin_reg;
        dig_next     = dig_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        unique case (phase_reg)
            PH_HOLD:
            begin
                if (cmd.load)
                begin
                    dig_cnt_next = DIG_CW'(NDIG);
                    if (cmd.hex)
                    begin
                        dig_next   = DW'(value);
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        bin_next     = value;
                        dig_next     = '0;
                        bit_cnt_next = BIT_CW'(ARG_BITS);
                        phase_next   = PH_CONV;
                    end
                end
                else if (cmd.pop)
                begin
                    dig_next     = {dig_reg[DW-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - DIG_CW'(1);
                end
            end
            PH_CONV:
            begin
                dig_next     = {adjusted[DW-2:0], bin_reg[ARG_BITS-1]};
                bin_next     = {bin_reg[ARG_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BIT_CW'(1);
                if (bit_cnt_reg == BIT_CW'(1))
                begin
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                if ((top_digit == 4'd0) && (dig_cnt_reg > DIG_CW'(1)))
                begin
                    dig_next     = {dig_reg[DW-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - DIG_CW'(1);
                end
                else
                begin
                    phase_next = PH_HOLD;
                end
            end
            default:
            begin
                phase_next = PH_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HOLD;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        dig_reg <= dig_next;
    end

endmodule

// ===== sv/format_string_integer_formatter.sv =====
// ---------------------------------------------------------------------------
// Integer format-string formatter
// Consumes one format byte per transaction and emits the formatted ASCII
// characters, each with its buffer position, store flag and running total.
// ---------------------------------------------------------------------------
//  Channel   Signals                                         Handshake
//  input     format_char, argument_value                     in_valid / in_ready
//  output    out_char, out_position, write_enable,           out_valid / out_ready
//            total_count, last_of_run
//  config    cfg_write_data (buffer size)                    cfg_write_en
//
// A literal, %c, %% or terminator goes from idle to a single-character emit state.
// Decimal conversions shift all ARG_BITS bits through the bit-serial BCD converter,
// skip leading zeros, hand over to the digit state and emit one character at a
// time, holding whenever the output stalls.
// Hexadecimal conversions skip the BCD converter and go through only the skip,
// hand-over and emit steps.
// Reset clears the pending percent, the character count and sets the buffer size
// to 65535. A stalled output holds the block; no character is dropped.
`timescale 1ns / 1ps

`include "format_string_integer_formatter_macros.svh"

module format_string_integer_formatter #(
    parameter int COUNT_BITS = 16,
    parameter int ARG_BITS   = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  format_char,
    input  logic [63:0] argument_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic [15:0] out_position,
    output logic        write_enable,
    output logic [15:0] total_count,
    output logic        last_of_run,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data
);

    localparam int NDIG  = (ARG_BITS * 30103) / 100000 + 1;
    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ONE   = 3'd1;
    localparam logic [2:0] ST_PRE   = 3'd2;
    localparam logic [2:0] ST_DIGIT = 3'd3;

    logic [2:0]            state_reg, state_next;
    logic                  pending_reg, pending_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [15:0]           size_reg;
    fsif_pkg::char_t       one_char_reg, one_char_next;
    logic                  term_reg, term_next;
    logic [1:0]            pre_cnt_reg, pre_cnt_next;
    logic                  pre_p_reg, pre_p_next;
    logic                  upper_reg, upper_next;

    logic                  out_valid_reg, out_valid_next;
    fsif_pkg::char_t       out_char_reg, out_char_next;
    logic [15:0]           out_pos_reg, out_pos_next;
    logic                  out_we_reg, out_we_next;
    logic [15:0]           out_total_reg, out_total_next;
    logic                  out_last_reg, out_last_next;

    fsif_pkg::dig_cmd_t    dig_cmd;
    fsif_pkg::dig_stat_t   dig_stat;
    logic [ARG_BITS-1:0]   arg;
    logic [ARG_BITS-1:0]   neg_arg;
    logic [ARG_BITS-1:0]   load_value;

    logic                  in_fire;
    logic                  emit_req;
    logic                  emit_go;
    logic                  size_nz;
    logic [CMP_W-1:0]      cnt_w;
    logic [CMP_W-1:0]      lim_w;
    logic                  below_lim;
    logic                  cnt_sat;
    logic                  prod_we;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [15:0]           term_pos;
    fsif_pkg::char_t       emit_char;
    logic                  emit_last;
    logic                  emit_term;

    assign arg     = argument_value[ARG_BITS-1:0];
    assign neg_arg = (~arg) + {{(ARG_BITS-1){1'b0}}, 1'b1};

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    assign size_nz   = (size_reg != 16'd0);
    assign cnt_w     = CMP_W'(cnt_reg);
    assign lim_w     = CMP_W'(size_reg - 16'd1);
    assign below_lim = (cnt_w < lim_w);
    assign cnt_sat   = (cnt_reg == COUNT_MAX);
    assign prod_we   = size_nz && below_lim && !cnt_sat;
    assign cnt_inc   = cnt_sat ? cnt_reg : cnt_reg + {{(COUNT_BITS-1){1'b0}}, 1'b1};
    assign term_pos  = !size_nz ? 16'd0 : (below_lim ? 16'(cnt_w) : 16'(lim_w));

    assign emit_req = (state_reg == ST_ONE) || (state_reg == ST_DIGIT) ||
                      ((state_reg == ST_PRE) && (pre_cnt_reg != 2'd0));
    assign emit_go  = emit_req && (!out_valid_reg || out_ready);

    always_comb
    begin
        emit_char = one_char_reg;
        emit_last = 1'b1;
        emit_term = 1'b0;
        unique case (state_reg)
            ST_ONE:
            begin
                emit_char = one_char_reg;
                emit_term = term_reg;
            end
            ST_PRE:
            begin
                emit_last = 1'b0;
                if (pre_cnt_reg == 2'd2)
                begin
                    emit_char = fsif_pkg::CH_ZERO;
                end
                else
                begin
                    emit_char = pre_p_reg ? fsif_pkg::CH_LC_X : fsif_pkg::CH_MINUS;
                end
            end
            ST_DIGIT:
            begin
                emit_char = fsif_pkg::digit_char(dig_stat.digit, upper_reg);
                emit_last = dig_stat.last;
            end
            default:
            begin
                emit_char = one_char_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        pending_next   = pending_reg;
        cnt_next       = cnt_reg;
        one_char_next  = one_char_reg;
        term_next      = term_reg;
        pre_cnt_next   = pre_cnt_reg;
        pre_p_next     = pre_p_reg;
        upper_next     = upper_reg;
        dig_cmd.load   = 1'b0;
        dig_cmd.hex    = 1'b0;
        dig_cmd.pop    = 1'b0;
        load_value     = arg;

        out_valid_next = out_valid_reg && !out_ready;
        out_char_next  = out_char_reg;
        out_pos_next   = out_pos_reg;
        out_we_next    = out_we_reg;
        out_total_next = out_total_reg;
        out_last_next  = out_last_reg;

        if (emit_go)
        begin
            out_valid_next = 1'b1;
            out_char_next  = emit_char;
            out_last_next  = emit_last;
            if (emit_term)
            begin
                out_pos_next   = term_pos;
                out_we_next    = size_nz;
                out_total_next = 16'(cnt_reg);
                cnt_next       = '0;
            end
            else
            begin
                out_pos_next   = 16'(cnt_reg);
                out_we_next    = prod_we;
                out_total_next = 16'(cnt_inc);
                cnt_next       = cnt_inc;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    term_next = 1'b0;
                    if (format_char == fsif_pkg::CH_NUL)
                    begin
                        one_char_next = fsif_pkg::CH_NUL;
                        term_next     = 1'b1;
                        pending_next  = 1'b0;
                        state_next    = ST_ONE;
                    end
                    else if (!pending_reg)
                    begin
                        if (format_char == fsif_pkg::CH_PERCENT)
                        begin
                            pending_next = 1'b1;
                        end
                        else
                        begin
                            one_char_next = format_char;
                            state_next    = ST_ONE;
                        end
                    end
                    else
                    begin
                        pending_next = 1'b0;
                        state_next   = ST_ONE;
                        case (format_char) inside
                            fsif_pkg::CH_LC_C:
                            begin
                                one_char_next = argument_value[7:0];
                            end
                            fsif_pkg::CH_PERCENT:
                            begin
                                one_char_next = fsif_pkg::CH_PERCENT;
                            end
                            fsif_pkg::CH_LC_D, fsif_pkg::CH_LC_U, fsif_pkg::CH_LC_X,
                            fsif_pkg::CH_UC_X, fsif_pkg::CH_LC_P:
                            begin
                                state_next   = ST_PRE;
                                dig_cmd.load = 1'b1;
                                dig_cmd.hex  = (format_char == fsif_pkg::CH_LC_X) ||
                                               (format_char == fsif_pkg::CH_UC_X) ||
                                               (format_char == fsif_pkg::CH_LC_P);
                                upper_next   = (format_char == fsif_pkg::CH_UC_X);
                                pre_p_next   = (format_char == fsif_pkg::CH_LC_P);
                                pre_cnt_next = 2'd0;
                                if (format_char == fsif_pkg::CH_LC_P)
                                begin
                                    pre_cnt_next = 2'd2;
                                end
                                else if ((format_char == fsif_pkg::CH_LC_D) &&
                                         arg[ARG_BITS-1])
                                begin
                                    pre_cnt_next = 2'd1;
                                    load_value   = neg_arg;
                                end
                            end
                            default:
                            begin
                                one_char_next = fsif_pkg::CH_QMARK;
                            end
                        endcase
                    end
                end
            end
            ST_ONE:
            begin
                if (emit_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PRE:
            begin
                if (emit_go)
                begin
                    pre_cnt_next = pre_cnt_reg - 2'd1;
                end
                else if ((pre_cnt_reg == 2'd0) && dig_stat.ready)
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (emit_go)
                begin
                    dig_cmd.pop = 1'b1;
                    if (dig_stat.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    fsif_digit_unit #(
        .ARG_BITS (ARG_BITS),
        .NDIG     (NDIG)
    ) u_digit_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (dig_cmd),
        .value (load_value),
        .stat  (dig_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pending_reg   <= 1'b0;
            cnt_reg       <= '0;
            size_reg      <= 16'hFFFF;
            pre_cnt_reg   <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            cnt_reg       <= cnt_next;
            pre_cnt_reg   <= pre_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                size_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        one_char_reg  <= one_char_next;
        term_reg      <= term_next;
        pre_p_reg     <= pre_p_next;
        upper_reg     <= upper_next;
        out_char_reg  <= out_char_next;
        out_pos_reg   <= out_pos_next;
        out_we_reg    <= out_we_next;
        out_total_reg <= out_total_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_char     = out_char_reg;
    assign out_position = out_pos_reg;
    assign write_enable = out_we_reg;
    assign total_count  = out_total_reg;
    assign last_of_run  = out_last_reg;

    // Digits are only released once the converter has finished and skipped zeros.
    `FSIF_ASSERT_IMPL(a_digit_ready, (state_reg == ST_DIGIT), dig_stat.ready)
    // A zero format byte always leads to a terminator transaction.
    `FSIF_ASSERT_NEXT(a_term_follows, (in_fire && (format_char == fsif_pkg::CH_NUL)),
                      ((state_reg == ST_ONE) && term_reg))
    // The character count saturates rather than wrapping.
    `FSIF_ASSERT_NEXT(a_count_saturates, (cnt_reg == COUNT_MAX),
                      ((cnt_reg == COUNT_MAX) || (cnt_reg == '0)))

endmodule
